// ===== design/video_captured_wavetable_oscillator_unit_assert.svh =====
`ifndef VIDEO_CAPTURED_WAVETABLE_OSCILLATOR_UNIT_ASSERT_SVH
`define VIDEO_CAPTURED_WAVETABLE_OSCILLATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define VCWO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("vcwo assertion failed");

// Next-cycle implication, checked outside reset.
`define VCWO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("vcwo assertion failed");

`endif

// ===== design/vcwo_pkg.sv =====
package vcwo_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);

  localparam int WAVE_W   = 8;
  localparam int POS_W    = 8;
  localparam int LINE_W   = 10;
  localparam int SAMPLE_W = 10;
  localparam int PERIOD_W = 11;

  localparam logic [LINE_W-1:0]   LINE_MAX         = 10'd1023;
  localparam logic [PERIOD_W-1:0] RATE_BASE        = 11'd1028;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET     = 11'd223;
  localparam logic [PERIOD_W-1:0] PERIOD_MIN       = 11'd5;
  localparam logic [LINE_W-1:0]   FIRST_LINE_RESET = 10'd36;
  localparam logic [LINE_W-1:0]   CV_LINE_RESET    = 10'd50;

  localparam logic [1:0] OP_FIELD_EDGE  = 2'd0;
  localparam logic [1:0] OP_LINE_SAMPLE = 2'd1;
  localparam logic [1:0] OP_RATE_TICK   = 2'd2;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic REG_FIRST_VIDEO_LINE = 1'b0;
  localparam logic REG_CV_LINE          = 1'b1;

  typedef struct packed {
    logic [1:0]          operation;
    logic                field_level;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [WAVE_W-1:0]   wave_sample;
    logic [POS_W-1:0]    read_position;
    logic [PERIOD_W-1:0] rate_period;
    logic                input_channel;
  } out_item_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [WAVE_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic [IDX_W-1:0]    pos;
    logic [PERIOD_W-1:0] period;
    logic                channel;
  } status_t;

endpackage

// ===== design/vcwo_wave_mem.sv =====
module vcwo_wave_mem
  import vcwo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  mem_req_t          req,
  output logic [WAVE_W-1:0] rd_data
);

  logic [WAVE_W-1:0]      wave_mem_r [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] written_r;
  logic [WAVE_W-1:0]      mem_rd_r;
  logic                   rd_written_r;
  logic [IDX_W-1:0]       rd_addr_r;
  logic                   fwd_r;
  logic [WAVE_W-1:0]      fwd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      wave_mem_r[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      mem_rd_r   <= wave_mem_r[req.raddr];
      rd_addr_r  <= req.raddr;
      fwd_data_r <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r    <= '0;
      rd_written_r <= 1'b0;
      fwd_r        <= 1'b0;
    end else begin
      if (req.we) begin
        written_r[req.waddr] <= 1'b1;
      end
      if (req.re) begin
        rd_written_r <= written_r[req.raddr];
        fwd_r        <= req.we && (req.waddr == req.raddr);
      end
    end
  end

  // Entries never written since reset read as the ramp value.
  always_comb begin
    if (fwd_r) begin
      rd_data = fwd_data_r;
    end else if (rd_written_r) begin
      rd_data = mem_rd_r;
    end else begin
      rd_data = WAVE_W'(rd_addr_r);
    end
  end

endmodule

// ===== design/vcwo_event_ctrl.sv =====
`include "video_captured_wavetable_oscillator_unit_assert.svh"

module vcwo_event_ctrl
  import vcwo_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  in_item_t          item,
  input  logic [LINE_W-1:0] first_line,
  input  logic [LINE_W-1:0] cv_line,
  output mem_req_t          mem_req,
  output status_t           status
);

  localparam logic [LINE_W:0]  OFF_LIMIT = (LINE_W + 1)'(TABLE_DEPTH);
  localparam logic [IDX_W-1:0] POS_LAST  = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [IDX_W:0]   POS_LIMIT = (IDX_W + 1)'(TABLE_DEPTH);

  logic [LINE_W-1:0]   line_r, line_nxt;
  logic                mode_r, mode_nxt;
  logic [IDX_W-1:0]    pos_r, pos_nxt;
  logic [PERIOD_W-1:0] period_r, period_nxt;
  logic [PERIOD_W-1:0] div_r, div_nxt;
  logic [LINE_W-1:0]   off;
  logic                in_window;

  assign off       = line_r - first_line;
  assign in_window = (line_r >= first_line) && ({1'b0, off} < OFF_LIMIT);

  always_comb begin
    line_nxt      = line_r;
    mode_nxt      = mode_r;
    pos_nxt       = pos_r;
    period_nxt    = period_r;
    div_nxt       = div_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = off[IDX_W-1:0];
    mem_req.wdata = item.sample[SAMPLE_W-1:2];
    if (accept) begin
      case (item.operation)
        OP_FIELD_EDGE: begin
          line_nxt = '0;
          mode_nxt = item.field_level;
        end
        OP_LINE_SAMPLE: begin
          if (mode_r) begin
            mem_req.we = in_window;
          end else if (line_r == cv_line) begin
            period_nxt = RATE_BASE - {1'b0, item.sample};
          end
          if (line_r != LINE_MAX) begin
            line_nxt = line_r + 1'b1;
          end
        end
        OP_RATE_TICK: begin
          if (div_r >= period_r) begin
            div_nxt = '0;
            pos_nxt = (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
          end else begin
            div_nxt = div_r + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    mem_req.re     = accept;
    mem_req.raddr  = pos_nxt;
    status.pos     = pos_nxt;
    status.period  = period_nxt;
    status.channel = !mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= '0;
      mode_r   <= 1'b0;
      pos_r    <= '0;
      period_r <= PERIOD_RESET;
      div_r    <= '0;
    end else begin
      line_r   <= line_nxt;
      mode_r   <= mode_nxt;
      pos_r    <= pos_nxt;
      period_r <= period_nxt;
      div_r    <= div_nxt;
    end
  end

  `VCWO_ASSERT_IMP(a_period_floor, clk, rst_n, 1'b1, period_r >= PERIOD_MIN)
  `VCWO_ASSERT_IMP(a_pos_range, clk, rst_n, 1'b1, {1'b0, pos_r} < POS_LIMIT)
  `VCWO_ASSERT_IMP(a_write_cause, clk, rst_n, mem_req.we,
                   accept && mode_r && (item.operation == OP_LINE_SAMPLE))

endmodule

// ===== design/video_captured_wavetable_oscillator_unit.sv =====
// Wavetable oscillator with a table captured from video lines.
// Input channel (in_valid, in_stall, in_item): one event per transfer, a field
// edge, a line sample or a rate tick. Output channel (out_valid, out_stall,
// out_item): exactly one result per event, in order, carrying the table value
// at the read position, the position, the rate period and the converter
// channel as they stand after that event.
// Each result passes the stage 1 and output registers. One event is taken
// every cycle while in_stall is low; it reads the wave table memory, and a
// captured line sample writes it in that cycle; the read data is registered.
// A stalled result waits in the output register while one more event may be
// taken into the stage behind it; in_stall rises only when both are full.
// Reset clears the counters, the read position and the valid flags of the
// table, so every entry reads as a ramp until it is captured, sets the period
// to 223 and loads the line registers with 36 and 50. No clearing pass is
// needed; events are taken from the first cycle after reset. The user must
// write the configuration port only while no event is in flight; not enforced.
`include "video_captured_wavetable_oscillator_unit_assert.svh"

module video_captured_wavetable_oscillator_unit
  import vcwo_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_item,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [LINE_W-1:0] first_line_r;
  logic [LINE_W-1:0] cv_line_r;
  logic              cfg_write;
  logic              reg_sel;

  logic              accept;
  mem_req_t          mem_req;
  status_t           status;
  logic [WAVE_W-1:0] rd_data;

  logic      s1_valid_r, s1_valid_nxt;
  status_t   s1_status_r;
  logic      s1_adv;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  assign cfg_pready = 1'b1;
  assign cfg_write  = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_line_r <= FIRST_LINE_RESET;
      cv_line_r    <= CV_LINE_RESET;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_FIRST_VIDEO_LINE: first_line_r <= cfg_pwdata[LINE_W-1:0];
        REG_CV_LINE:          cv_line_r    <= cfg_pwdata[LINE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIRST_VIDEO_LINE: cfg_prdata = CFG_DATA_W'(first_line_r);
      REG_CV_LINE:          cfg_prdata = CFG_DATA_W'(cv_line_r);
      default:              cfg_prdata = '0;
    endcase
  end

  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  vcwo_event_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .item       (in_item),
    .first_line (first_line_r),
    .cv_line    (cv_line_r),
    .mem_req    (mem_req),
    .status     (status)
  );

  vcwo_wave_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_comb begin
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_status_r <= status;
    end
    if (s1_adv) begin
      out_item_r.wave_sample   <= rd_data;
      out_item_r.read_position <= POS_W'(s1_status_r.pos);
      out_item_r.rate_period   <= s1_status_r.period;
      out_item_r.input_channel <= s1_status_r.channel;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `VCWO_ASSERT_NXT(a_accept_fills_s1, clk, rst_n, accept, s1_valid_r)
  `VCWO_ASSERT_NXT(a_s1_holds, clk, rst_n, s1_valid_r && !s1_adv,
                   s1_valid_r && $stable(s1_status_r) && $stable(rd_data))
  `VCWO_ASSERT_IMP(a_out_from_s1, clk, rst_n, $rose(out_valid_r), $past(s1_valid_r))

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import vcwo_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_GAP = 14;
  localparam int PRINT_CAP = 100;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  logic [WAVE_W-1:0]   wave_mem [TABLE_DEPTH];
  logic [LINE_W-1:0]   line_cnt;
  logic                vid_mode;
  logic [POS_W-1:0]    play_pos;
  logic [PERIOD_W-1:0] period_q;
  logic [PERIOD_W-1:0] div_cnt;
  logic [LINE_W-1:0]   first_line_q;
  logic [LINE_W-1:0]   cv_line_q;

  out_item_t due_results[$];
  int        err_cnt = 0;
  int        sent_cnt = 0;
  int        cycle_cnt = 0;
  bit        idle_on = 1'b1;

  dir_row_t dir_rows [27] = '{
    '{'{OP_UNUSED,      1'b1, 10'h3ff}, 1'b1, '{8'd0,   8'd0, 11'd223,  1'b1}},
    '{'{OP_RATE_TICK,   1'b1, 10'h3ff}, 1'b1, '{8'd0,   8'd0, 11'd223,  1'b1}},
    '{'{OP_FIELD_EDGE,  1'b0, 10'h3ff}, 1'b1, '{8'd0,   8'd0, 11'd223,  1'b1}},
    '{'{OP_LINE_SAMPLE, 1'b0, 10'h3ff}, 1'b1, '{8'd0,   8'd0, 11'd5,    1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'd0,   8'd0, 11'd5,    1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'd0,   8'd0, 11'd5,    1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'd0,   8'd0, 11'd5,    1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'd0,   8'd0, 11'd5,    1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'd1,   8'd1, 11'd5,    1'b1}},
    '{'{OP_LINE_SAMPLE, 1'b0, 10'h000}, 1'b1, '{8'd1,   8'd1, 11'd5,    1'b1}},
    '{'{OP_FIELD_EDGE,  1'b1, 10'h000}, 1'b1, '{8'd1,   8'd1, 11'd5,    1'b0}},
    '{'{OP_LINE_SAMPLE, 1'b1, 10'h3ff}, 1'b1, '{8'd1,   8'd1, 11'd5,    1'b0}},
    '{'{OP_LINE_SAMPLE, 1'b1, 10'h3fc}, 1'b1, '{8'hff,  8'd1, 11'd5,    1'b0}},
    '{'{OP_LINE_SAMPLE, 1'b1, 10'h000}, 1'b1, '{8'hff,  8'd1, 11'd5,    1'b0}},
    '{'{OP_LINE_SAMPLE, 1'b1, 10'h2aa}, 1'b1, '{8'hff,  8'd1, 11'd5,    1'b0}},
    '{'{OP_LINE_SAMPLE, 1'b0, 10'h155}, 1'b1, '{8'hff,  8'd1, 11'd5,    1'b0}},
    '{'{OP_FIELD_EDGE,  1'b0, 10'h2aa}, 1'b1, '{8'hff,  8'd1, 11'd5,    1'b1}},
    '{'{OP_LINE_SAMPLE, 1'b0, 10'h000}, 1'b1, '{8'hff,  8'd1, 11'd1028, 1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'hff,  8'd1, 11'd1028, 1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'hff,  8'd1, 11'd1028, 1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'hff,  8'd1, 11'd1028, 1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'hff,  8'd1, 11'd1028, 1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'hff,  8'd1, 11'd1028, 1'b1}},
    '{'{OP_RATE_TICK,   1'b0, 10'h000}, 1'b1, '{8'hff,  8'd1, 11'd1028, 1'b1}},
    '{'{OP_FIELD_EDGE,  1'b0, 10'h155}, 1'b0, '0},
    '{'{OP_LINE_SAMPLE, 1'b1, 10'h3ff}, 1'b0, '0},
    '{'{OP_RATE_TICK,   1'b1, 10'h2aa}, 1'b0, '0}
  };

  video_captured_wavetable_oscillator_unit u_dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("video_captured_wavetable_oscillator_unit verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt < PRINT_CAP)
      $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  function automatic in_item_t make_event(input logic [1:0] op, input logic lvl,
                                          input logic [SAMPLE_W-1:0] smp);
    in_item_t ev;
    ev.operation = op;
    ev.field_level = lvl;
    ev.sample = smp;
    return ev;
  endfunction

  function automatic out_item_t advance_oscillator(input in_item_t ev);
    out_item_t r;
    int offset;
    offset = int'(line_cnt) - int'(first_line_q);
    case (ev.operation)
      OP_FIELD_EDGE: begin
        line_cnt = '0;
        vid_mode = ev.field_level;
      end
      OP_LINE_SAMPLE: begin
        if (vid_mode) begin
          if (offset >= 0 && offset < TABLE_DEPTH)
            wave_mem[offset] = ev.sample[SAMPLE_W-1:2];
        end else if (line_cnt == cv_line_q) begin
          period_q = RATE_BASE - PERIOD_W'(ev.sample);
        end
        if (line_cnt != LINE_MAX)
          line_cnt = line_cnt + 1'b1;
      end
      OP_RATE_TICK: begin
        if (div_cnt >= period_q) begin
          div_cnt = '0;
          play_pos = POS_W'((int'(play_pos) + 1) % TABLE_DEPTH);
        end else begin
          div_cnt = div_cnt + 1'b1;
        end
      end
      default: ;
    endcase
    r.wave_sample = wave_mem[play_pos];
    r.read_position = play_pos;
    r.rate_period = period_q;
    r.input_channel = ~vid_mode;
    return r;
  endfunction

  task automatic push_event(input in_item_t ev, input bit typed = 1'b0,
                            input out_item_t typed_want = '0);
    int gap;
    out_item_t pred;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= ev;
    do @(posedge clk); while (in_stall);
    pred = advance_oscillator(ev);
    due_results.push_back(typed ? typed_want : pred);
    sent_cnt++;
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_results.size() == 0) begin
      report_mismatch("transfer with no result due, wave_sample", got.wave_sample, 0);
    end else begin
      want = due_results.pop_front();
      if (got.wave_sample !== want.wave_sample)
        report_mismatch("wave_sample", got.wave_sample, want.wave_sample);
      if (got.read_position !== want.read_position)
        report_mismatch("read_position", got.read_position, want.read_position);
      if (got.rate_period !== want.rate_period)
        report_mismatch("rate_period", got.rate_period, want.rate_period);
      if (got.input_channel !== want.input_channel)
        report_mismatch("input_channel", got.input_channel, want.input_channel);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic reg_sel, input logic [LINE_W-1:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_sel, 2'b00};
    cfg_pwdata <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== CFG_DATA_W'(value))
      report_mismatch("register readback", cfg_prdata, value);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (reg_sel == REG_FIRST_VIDEO_LINE)
      first_line_q = value;
    else
      cv_line_q = value;
  endtask

  task automatic random_fields(input int n_items);
    int stop_at;
    int target;
    logic lvl;
    stop_at = sent_cnt + n_items;
    while (sent_cnt < stop_at) begin
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) begin
        push_event(make_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                              SAMPLE_W'($urandom_range(0, 1023))));
      end else begin
        lvl = 1'($urandom_range(0, 1));
        push_event(make_event(OP_FIELD_EDGE, lvl, SAMPLE_W'($urandom_range(0, 1023))));
        target = lvl ? int'(first_line_q) + $urandom_range(1, 16)
                     : int'(cv_line_q) + $urandom_range(1, 3);
        if ($urandom_range(0, 4) == 0)
          target = $urandom_range(0, target);
        for (int i = 0; i < target; i++) begin
          if ($urandom_range(0, 2) == 0)
            push_event(make_event(OP_RATE_TICK, 1'($urandom_range(0, 1)),
                                  SAMPLE_W'($urandom_range(0, 1023))));
          push_event(make_event(OP_LINE_SAMPLE, 1'($urandom_range(0, 1)),
                                SAMPLE_W'($urandom_range(0, 1023))));
        end
      end
    end
  endtask

  initial begin : result_monitor
    int hold;
    forever begin
      hold = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
      check_result(out_item);
    end
  end

  initial begin : stimulus
    for (int i = 0; i < TABLE_DEPTH; i++)
      wave_mem[i] = WAVE_W'(i);
    line_cnt = '0;
    vid_mode = 1'b0;
    play_pos = '0;
    period_q = PERIOD_RESET;
    div_cnt = '0;
    first_line_q = FIRST_LINE_RESET;
    cv_line_q = CV_LINE_RESET;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    cfg_write(REG_FIRST_VIDEO_LINE, 10'd0);
    cfg_write(REG_CV_LINE, 10'd0);
    foreach (dir_rows[i])
      push_event(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
    settle();

    cfg_write(REG_FIRST_VIDEO_LINE, FIRST_LINE_RESET);
    cfg_write(REG_CV_LINE, CV_LINE_RESET);
    random_fields(260);
    settle();

    cfg_write(REG_FIRST_VIDEO_LINE, LINE_W'($urandom_range(0, 60)));
    cfg_write(REG_CV_LINE, LINE_W'($urandom_range(0, 60)));
    random_fields(260);
    settle();

    if (err_cnt == 0)
      $display("video_captured_wavetable_oscillator_unit verification clean");
    else
      $display("video_captured_wavetable_oscillator_unit verification failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/vcwo_pkg.sv
design/vcwo_wave_mem.sv
design/vcwo_event_ctrl.sv
design/video_captured_wavetable_oscillator_unit.sv
tb/testbench.sv
